### rtl/olde_pkg.sv
// package: types, codes and sizes shared by the ordered list deque engine
`timescale 1ns / 1ps

package olde_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;

    localparam logic [2:0] MODE_INS_FRONT = 3'd0;
    localparam logic [2:0] MODE_INS_BACK  = 3'd1;
    localparam logic [2:0] MODE_REM_FRONT = 3'd2;
    localparam logic [2:0] MODE_REM_BACK  = 3'd3;
    localparam logic [2:0] MODE_DELETE    = 3'd4;
    localparam logic [2:0] MODE_SEARCH    = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]              mode;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] value_out;
        logic [IDX_W-1:0]        position;
        logic [CNT_W-1:0]        count;
    } t_out_item;

    // per-cell load command, priority load_new > take_left > take_right
    typedef struct packed {
        logic load_new;
        logic take_left;
        logic take_right;
    } t_cell_cmd;

endpackage

### rtl/ordered_list_deque_engine.sv
// top level: bounded ordered list of signed values used as a deque
`timescale 1ns / 1ps

// usage
//   input channel (i_in_valid / o_in_ready / i_in_data) carries one operation
//   per transfer: insert front or back, remove front or back, delete the
//   first entry equal to a value, or search for a value
//   output channel (o_out_valid / i_out_ready / o_out_data) returns one
//   result per operation: status, value, position and count after the op
//   the result sits in the output register in the cycle after the transfer;
//   throughput is one operation per cycle unless stalled, as the search is a
//   parallel compare in every cell and the shift is one step of the cell row
//   the output register frees in the same cycle it is taken, so a new input
//   transfer is taken whenever the result slot is empty or being read
//   receiver stall: while a result waits and i_out_ready is low, o_in_ready
//   drops and the list holds still
//   reset (i_rst_n low, synchronous): count goes to zero and no result is
//   pending; entry contents are left as they are and never read before write

module ordered_list_deque_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  olde_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output olde_pkg::t_out_item o_out_data
);

    logic [olde_pkg::CNT_W-1:0] r_count;
    logic [olde_pkg::CNT_W-1:0] n_count;
    logic                       r_out_valid;
    olde_pkg::t_out_item        r_out;
    olde_pkg::t_out_item        n_out;

    logic                              in_fire;
    olde_pkg::t_cell_cmd               cmd [olde_pkg::DEPTH];
    logic signed [olde_pkg::VAL_W-1:0] cell_value [olde_pkg::DEPTH];
    logic [olde_pkg::DEPTH-1:0]        match;
    logic [olde_pkg::IDX_W-1:0]        back_idx;

    // result slot is free when empty or being taken this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    // row of cells, position 0 is the front
    for (genvar g = 0; g < olde_pkg::DEPTH; g++) begin : g_cell
        logic signed [olde_pkg::VAL_W-1:0] left_value;
        logic signed [olde_pkg::VAL_W-1:0] right_value;

        if (g == 0) begin : g_front
            assign left_value = '0;
        end else begin : g_mid_left
            assign left_value = cell_value[g-1];
        end

        if (g == olde_pkg::DEPTH - 1) begin : g_back
            assign right_value = cell_value[g];
        end else begin : g_mid_right
            assign right_value = cell_value[g+1];
        end

        olde_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd[g]),
            .i_new   (i_in_data.value),
            .i_left  (left_value),
            .i_right (right_value),
            .i_key   (i_in_data.value),
            .o_value (cell_value[g]),
            .o_match (match[g])
        );
    end

    olde_ctrl u_ctrl (
        .i_fire     (in_fire),
        .i_item     (i_in_data),
        .i_count    (r_count),
        .i_match    (match),
        .i_front    (cell_value[0]),
        .i_back     (cell_value[back_idx]),
        .o_cmd      (cmd),
        .o_back_idx (back_idx),
        .o_result   (n_out),
        .o_count    (n_count)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= olde_pkg::CNT_W'(olde_pkg::DEPTH))
        else $error("occupancy above depth");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && r_count == olde_pkg::CNT_W'(olde_pkg::DEPTH) &&
        (i_in_data.mode == olde_pkg::MODE_INS_FRONT ||
         i_in_data.mode == olde_pkg::MODE_INS_BACK)
        |=> o_out_data.status == olde_pkg::ST_FULL && $stable(r_count))
        else $error("insert into full list not dropped");

    a_empty_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && r_count == '0 &&
        (i_in_data.mode == olde_pkg::MODE_REM_FRONT ||
         i_in_data.mode == olde_pkg::MODE_REM_BACK)
        |=> o_out_data.status == olde_pkg::ST_EMPTY && r_count == '0)
        else $error("removal from empty list not flagged");

    a_count_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.count == r_count)
        else $error("reported count differs from held count");

endmodule

### rtl/olde_cell.sv
// one storage cell of the list row: holds an entry, shifts, compares with the key
`timescale 1ns / 1ps

module olde_cell (
    input  logic                              i_clk,
    input  olde_pkg::t_cell_cmd               i_cmd,
    input  logic signed [olde_pkg::VAL_W-1:0] i_new,
    input  logic signed [olde_pkg::VAL_W-1:0] i_left,
    input  logic signed [olde_pkg::VAL_W-1:0] i_right,
    input  logic signed [olde_pkg::VAL_W-1:0] i_key,
    output logic signed [olde_pkg::VAL_W-1:0] o_value,
    output logic                              o_match
);

    logic signed [olde_pkg::VAL_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_new) begin
            r_value <= i_new;
        end else if (i_cmd.take_left) begin
            r_value <= i_left;
        end else if (i_cmd.take_right) begin
            r_value <= i_right;
        end
    end

    assign o_value = r_value;
    assign o_match = (r_value == i_key);

endmodule

### rtl/olde_ctrl.sv
// operation decode: first-match search, result build and cell commands
`timescale 1ns / 1ps

module olde_ctrl (
    input  logic                              i_fire,
    input  olde_pkg::t_in_item                i_item,
    input  logic [olde_pkg::CNT_W-1:0]        i_count,
    input  logic [olde_pkg::DEPTH-1:0]        i_match,
    input  logic signed [olde_pkg::VAL_W-1:0] i_front,
    input  logic signed [olde_pkg::VAL_W-1:0] i_back,
    output olde_pkg::t_cell_cmd               o_cmd [olde_pkg::DEPTH],
    output logic [olde_pkg::IDX_W-1:0]        o_back_idx,
    output olde_pkg::t_out_item               o_result,
    output logic [olde_pkg::CNT_W-1:0]        o_count
);

    logic [olde_pkg::DEPTH-1:0] live_match;
    logic                       hit;
    logic [olde_pkg::IDX_W-1:0] hit_idx;
    logic                       full;
    logic                       empty;
    logic [olde_pkg::CNT_W-1:0] count_m1;

    assign full     = (i_count >= olde_pkg::CNT_W'(olde_pkg::DEPTH));
    assign empty    = (i_count == '0);
    assign count_m1 = i_count - olde_pkg::CNT_W'(1);
    assign o_back_idx = count_m1[olde_pkg::IDX_W-1:0];

    // only occupied positions take part in the search
    always_comb begin
        for (int i = 0; i < olde_pkg::DEPTH; i++) begin
            live_match[i] = i_match[i] && (olde_pkg::CNT_W'(i) < i_count);
        end
    end

    // lowest matching position wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = olde_pkg::DEPTH - 1; i >= 0; i--) begin
            if (live_match[i]) begin
                hit     = 1'b1;
                hit_idx = olde_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        o_result.status    = olde_pkg::ST_OK;
        o_result.value_out = '0;
        o_result.position  = '0;
        o_count            = i_count;
        for (int i = 0; i < olde_pkg::DEPTH; i++) begin
            o_cmd[i] = '0;
        end
        unique case (i_item.mode) inside
            olde_pkg::MODE_INS_FRONT: begin
                if (full) begin
                    o_result.status = olde_pkg::ST_FULL;
                end else begin
                    o_result.value_out = i_item.value;
                    o_count            = i_count + olde_pkg::CNT_W'(1);
                    o_cmd[0].load_new  = i_fire;
                    for (int i = 1; i < olde_pkg::DEPTH; i++) begin
                        o_cmd[i].take_left = i_fire && (olde_pkg::CNT_W'(i) <= i_count);
                    end
                end
            end
            olde_pkg::MODE_INS_BACK: begin
                if (full) begin
                    o_result.status = olde_pkg::ST_FULL;
                end else begin
                    o_result.value_out = i_item.value;
                    o_result.position  = i_count[olde_pkg::IDX_W-1:0];
                    o_count            = i_count + olde_pkg::CNT_W'(1);
                    for (int i = 0; i < olde_pkg::DEPTH; i++) begin
                        o_cmd[i].load_new = i_fire && (olde_pkg::CNT_W'(i) == i_count);
                    end
                end
            end
            olde_pkg::MODE_REM_FRONT: begin
                if (empty) begin
                    o_result.status = olde_pkg::ST_EMPTY;
                end else begin
                    o_result.value_out = i_front;
                    o_count            = count_m1;
                    for (int i = 0; i < olde_pkg::DEPTH; i++) begin
                        o_cmd[i].take_right = i_fire;
                    end
                end
            end
            olde_pkg::MODE_REM_BACK: begin
                if (empty) begin
                    o_result.status = olde_pkg::ST_EMPTY;
                end else begin
                    o_result.value_out = i_back;
                    o_result.position  = o_back_idx;
                    o_count            = count_m1;
                end
            end
            olde_pkg::MODE_DELETE, olde_pkg::MODE_SEARCH: begin
                if (!hit) begin
                    o_result.status = olde_pkg::ST_NOT_FOUND;
                end else begin
                    // a match equals the key, so the key is the found value
                    o_result.value_out = i_item.value;
                    o_result.position  = hit_idx;
                    if (i_item.mode == olde_pkg::MODE_DELETE) begin
                        o_count = count_m1;
                        for (int i = 0; i < olde_pkg::DEPTH; i++) begin
                            o_cmd[i].take_right = i_fire &&
                                (olde_pkg::IDX_W'(i) >= hit_idx);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        o_result.count = o_count;
    end

endmodule
